FILE: design/irps_pkg.sv
// shared types and constants of the ir proximity scan sequencer
package irps_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int WAIT_W = 16;
  localparam int LED_W = 4;
  localparam int READ_W = 13;
  localparam int IDX_W = 4;
  localparam int PAIRS = 4;
  localparam int ROW_W = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int OUT_W = 40;

  localparam logic [WAIT_W-1:0] SHORT_WAIT_RST = 16'd645;
  localparam logic [WAIT_W-1:0] LONG_WAIT_RST = 16'd3870;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_RD_AMB  = 2'd1,
    CMD_RD_REFL = 2'd2,
    CMD_STOP    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SHORT_WAIT = 1'b0,
    REG_LONG_WAIT  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              tick_amb;
    logic              tick_lit;
    logic              rd_amb;
    logic              rd_refl;
    logic [ROW_W-1:0]  row;
    logic              half;
    logic              idx_ok;
    logic [LED_W-1:0]  led;
    logic [WAIT_W-1:0] wait_ticks;
  } op_t;

  typedef struct packed {
    logic [LED_W-1:0]  led_mask;
    logic [WAIT_W-1:0] wait_ticks;
    logic [READ_W-1:0] read_value;
  } res_t;

endpackage

FILE: design/irps_seq.sv
// scan sequencer: phase, pair, led lines and wait registers
module irps_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  irps_pkg::cmd_t                    cmd,
  input  logic [irps_pkg::IDX_W-1:0]        sensor_index,
  input  logic                              cfg_we,
  input  logic [irps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [irps_pkg::WAIT_W-1:0]       cfg_data,
  output irps_pkg::op_t                     op
);
  import irps_pkg::*;

  logic              lit_phase, lit_phase_next;
  logic [ROW_W-1:0]  pair, pair_next;
  logic [LED_W-1:0]  led, led_next;
  logic [WAIT_W-1:0] short_wait, long_wait;
  logic [LED_W-1:0]  pair_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_wait <= SHORT_WAIT_RST;
      long_wait  <= LONG_WAIT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_SHORT_WAIT: short_wait <= cfg_data;
        REG_LONG_WAIT:  long_wait  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_phase <= 1'b0;
      pair      <= '0;
      led       <= '0;
    end else if (accept) begin
      lit_phase <= lit_phase_next;
      pair      <= pair_next;
      led       <= led_next;
    end
  end

  assign pair_bit = LED_W'(1) << pair;

  always_comb begin
    lit_phase_next = lit_phase;
    pair_next      = pair;
    led_next       = led;
    op             = '0;
    op.row         = sensor_index[ROW_W-1:0];
    op.half        = sensor_index[ROW_W];
    op.idx_ok      = ~sensor_index[IDX_W-1];
    unique case (cmd)
      CMD_TICK: begin
        op.row = pair;
        if (!lit_phase) begin
          led_next        = led | pair_bit;
          op.wait_ticks   = short_wait;
          op.tick_amb     = 1'b1;
          lit_phase_next  = 1'b1;
        end else begin
          led_next        = led & ~pair_bit;
          op.wait_ticks   = long_wait;
          op.tick_lit     = 1'b1;
          lit_phase_next  = 1'b0;
          pair_next       = pair + ROW_W'(1);
        end
      end
      CMD_RD_AMB:  op.rd_amb = 1'b1;
      CMD_RD_REFL: op.rd_refl = 1'b1;
      CMD_STOP:    led_next = '0;
      default: ;
    endcase
    op.led = led_next;
  end

endmodule

FILE: design/irps_store.sv
// ambient and reflected memories with read-modify-write stage and bypass
module irps_store #(
  parameter int SAMPLE_BITS = irps_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic                   adv,
  input  irps_pkg::op_t          op,
  input  logic [SAMPLE_BITS-1:0] sample_low,
  input  logic [SAMPLE_BITS-1:0] sample_high,
  output irps_pkg::res_t         res
);
  import irps_pkg::*;

  localparam int AW = 2 * SAMPLE_BITS;
  localparam int RB = SAMPLE_BITS + 1;
  localparam int RW = 2 * RB;

  logic [AW-1:0] amb_mem [PAIRS];
  logic [RW-1:0] refl_mem [PAIRS];
  logic [PAIRS-1:0] amb_vld, refl_vld;

  op_t                    s1_op;
  logic [SAMPLE_BITS-1:0] s1_low, s1_high;
  logic [AW-1:0]          amb_q, amb_byp_d, amb_row, amb_wdata;
  logic [RW-1:0]          refl_q, refl_byp_d, refl_row, refl_wdata;
  logic                   amb_v, refl_v, amb_byp, refl_byp;
  logic [SAMPLE_BITS-1:0] amb_half;
  logic [RB-1:0]          refl_half, diff_low, diff_high;
  logic signed [31:0]     rv32;

  always_ff @(posedge clk) begin
    if (adv && s1_op.tick_amb) amb_mem[s1_op.row] <= amb_wdata;
    if (adv && s1_op.tick_lit) refl_mem[s1_op.row] <= refl_wdata;
    if (load) begin
      amb_q  <= amb_mem[op.row];
      refl_q <= refl_mem[op.row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amb_vld  <= '0;
      refl_vld <= '0;
    end else begin
      if (adv && s1_op.tick_amb) amb_vld[s1_op.row] <= 1'b1;
      if (adv && s1_op.tick_lit) refl_vld[s1_op.row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_op      <= op;
      s1_low     <= sample_low;
      s1_high    <= sample_high;
      amb_v      <= amb_vld[op.row];
      refl_v     <= refl_vld[op.row];
      amb_byp    <= adv && s1_op.tick_amb && (s1_op.row == op.row);
      refl_byp   <= adv && s1_op.tick_lit && (s1_op.row == op.row);
      amb_byp_d  <= amb_wdata;
      refl_byp_d <= refl_wdata;
    end
  end

  always_comb begin
    amb_row  = amb_byp ? amb_byp_d : (amb_v ? amb_q : '0);
    refl_row = refl_byp ? refl_byp_d : (refl_v ? refl_q : '0);
    amb_wdata  = {s1_high, s1_low};
    diff_low   = {1'b0, amb_row[SAMPLE_BITS-1:0]} - {1'b0, s1_low};
    diff_high  = {1'b0, amb_row[AW-1:SAMPLE_BITS]} - {1'b0, s1_high};
    refl_wdata = {diff_high, diff_low};
    amb_half   = s1_op.half ? amb_row[AW-1:SAMPLE_BITS] : amb_row[SAMPLE_BITS-1:0];
    refl_half  = s1_op.half ? refl_row[RW-1:RB] : refl_row[RB-1:0];
    rv32 = '0;
    if (s1_op.idx_ok && s1_op.rd_amb)  rv32 = 32'(amb_half);
    if (s1_op.idx_ok && s1_op.rd_refl) rv32 = 32'(signed'(refl_half));
    res.led_mask   = s1_op.led;
    res.wait_ticks = s1_op.wait_ticks;
    res.read_value = rv32[READ_W-1:0];
  end

endmodule

FILE: design/ir_proximity_scan_sequencer.sv
// top level of the ir proximity scan sequencer
// pipeline: two register stages, the s1 stage and the output register, the result is registered as s1 advances
// throughput: one transaction per cycle while the output is not stalled, also back to back on the same pair
// the sensor memories are read at the input transaction and written as it moves to the output
// reset: phase, pair and leds cleared, waits to 645 and 3870, stored values read zero
module ir_proximity_scan_sequencer #(
  parameter int SAMPLE_BITS = irps_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // sample_low, sample_high, sensor_index, zero fill
  input  logic [((2*SAMPLE_BITS+irps_pkg::IDX_W+7)/8)*8-1:0] s_tdata,
  // cmd
  input  logic [1:0]                             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // led_mask, wait_ticks, read_value, zero fill
  output logic [irps_pkg::OUT_W-1:0]             m_tdata,
  input  logic                                   cfg_we,
  input  logic [irps_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [irps_pkg::WAIT_W-1:0]            cfg_data
);
  import irps_pkg::*;

  logic in_fire, s1_fire, s1_valid;
  op_t  op;
  res_t res;
  logic [SAMPLE_BITS-1:0] sample_low, sample_high;
  logic [IDX_W-1:0] sensor_index;

  assign sample_low   = s_tdata[SAMPLE_BITS-1:0];
  assign sample_high  = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign sensor_index = s_tdata[2*SAMPLE_BITS+IDX_W-1:2*SAMPLE_BITS];

  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign in_fire  = s_tvalid && s_tready;

  irps_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_fire),
    .cmd          (cmd_t'(s_tuser)),
    .sensor_index (sensor_index),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .op           (op)
  );

  irps_store #(.SAMPLE_BITS(SAMPLE_BITS)) u_store (
    .clk         (clk),
    .rst         (rst),
    .load        (in_fire),
    .adv         (s1_fire),
    .op          (op),
    .sample_low  (sample_low),
    .sample_high (sample_high),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_fire) s1_valid <= 1'b1;
      else if (s1_fire) s1_valid <= 1'b0;
      if (s1_fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_tdata <= OUT_W'({res.read_value, res.wait_ticks, res.led_mask});
    end
  end

endmodule

FILE: design/irps_checker.sv
// port-level checker of the ir proximity scan sequencer and its bind
module irps_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [irps_pkg::OUT_W-1:0] m_tdata
);
  import irps_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  a_led_onehot0: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[LED_W-1:0]))
    else $error("more than one led pair on");

  a_wait_no_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[LED_W+WAIT_W-1:LED_W] != '0)
      |-> m_tdata[LED_W+WAIT_W+READ_W-1:LED_W+WAIT_W] == '0)
    else $error("tick result carries a read value");

  a_ready_after_rst: assert property (@(posedge clk)
    !rst && $past(rst) |-> s_tready && !m_tvalid)
    else $error("not empty after reset");

endmodule

bind ir_proximity_scan_sequencer irps_checker u_irps_checker (.*);
